// ===== hdl/tcc_pkg.sv =====
`default_nettype none
package tcc_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int TAB_WIDTH      = 8;
  localparam int FIRST_TEXT_ROW = 1;

  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int ATTR_W  = 2 * COLOR_W;
  localparam int WORD_W  = ATTR_W + CHAR_W;
  localparam int IDX_W   = 11;
  localparam int IDX_CALC_W = ROW_W + COL_W;
  localparam int COL_COUNT  = 1 << COL_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = COLOR_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXT_COLOR = 1'b0,
    REG_BACK_COLOR = 1'b1
  } cfg_reg_t;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

  localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 4'd7;
  localparam logic [COLOR_W-1:0] BACK_COLOR_RESET = 4'd0;

  typedef struct packed {
    logic              cell_write;
    logic [IDX_W-1:0]  cell_address;
    logic [WORD_W-1:0] cell_word;
    logic              scroll_up;
    logic              clear_screen;
    logic [IDX_W-1:0]  cursor_index;
  } tcc_result_t;

  typedef logic [COL_W:0] tab_stop_t [COL_COUNT];

  function automatic tab_stop_t tab_stops();
    tab_stop_t t;
    for (int i = 0; i < COL_COUNT; i++) begin
      t[i] = (COL_W+1)'(i + TAB_WIDTH - (i % TAB_WIDTH));
    end
    return t;
  endfunction

  // next tab stop for every column value
  localparam tab_stop_t TAB_STOPS = tab_stops();

  function automatic logic [IDX_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [IDX_CALC_W-1:0] p;
    p = IDX_CALC_W'(row) * IDX_CALC_W'(SCREEN_COLUMNS) + IDX_CALC_W'(col);
    return p[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/tcc_if.sv =====
`default_nettype none
interface tcc_in_if import tcc_pkg::*;;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, mode, char_code, input ready);
  modport sink   (input valid, mode, char_code, output ready);
endinterface

interface tcc_out_if import tcc_pkg::*;;
  logic              valid;
  logic              ready;
  logic              cell_write;
  logic [IDX_W-1:0]  cell_address;
  logic [WORD_W-1:0] cell_word;
  logic              scroll_up;
  logic              clear_screen;
  logic [IDX_W-1:0]  cursor_index;

  modport source (output valid, cell_write, cell_address, cell_word, scroll_up,
                  clear_screen, cursor_index, input ready);
  modport sink   (input valid, cell_write, cell_address, cell_word, scroll_up,
                  clear_screen, cursor_index, output ready);
endinterface
`default_nettype wire

// ===== hdl/text_console_cursor_engine.sv =====
// Text console cursor engine: one byte in, one result out, at one item per clock
// sustained while the output is not stalled. An accepted item sits in an input
// register, then the cursor update and cell write are worked out and land in the
// result register once the result register is free. The cursor column and row
// registers are updated once per item, which is the loop that sets the one-cycle
// rate. Results always come one per item; a result that is not taken holds the
// pipeline while the input register can still take one more item. Colour registers
// are to be written through the cfg port only while no item is in flight; the block
// itself does not enforce this. There is no clearing pass after reset.
`default_nettype none
module text_console_cursor_engine import tcc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tcc_in_if.sink                     in_item,
  tcc_out_if.source                  out_item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic               s1_valid_r;
  logic               s1_mode_r;
  logic [CHAR_W-1:0]  s1_char_r;
  logic               out_valid_r;
  tcc_result_t        out_r;
  tcc_result_t        res;
  logic [COLOR_W-1:0] text_color_r;
  logic [COLOR_W-1:0] back_color_r;
  logic               s1_adv;
  logic               in_acc;

  assign s1_adv        = s1_valid_r && (!out_valid_r || out_item.ready);
  assign in_item.ready = !s1_valid_r || s1_adv;
  assign in_acc        = in_item.valid && in_item.ready;

  tcc_cursor u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .mode      (s1_mode_r),
    .char_code (s1_char_r),
    .attr      ({back_color_r, text_color_r}),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= TEXT_COLOR_RESET;
      back_color_r <= BACK_COLOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TEXT_COLOR: text_color_r <= cfg_wdata;
        REG_BACK_COLOR: back_color_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r <= in_item.mode;
      s1_char_r <= in_item.char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) out_r <= res;
  end

  assign out_item.valid        = out_valid_r;
  assign out_item.cell_write   = out_r.cell_write;
  assign out_item.cell_address = out_r.cell_address;
  assign out_item.cell_word    = out_r.cell_word;
  assign out_item.scroll_up    = out_r.scroll_up;
  assign out_item.clear_screen = out_r.clear_screen;
  assign out_item.cursor_index = out_r.cursor_index;

  a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r)
    else $error("pending item dropped from input register");

  a_scroll_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.scroll_up && out_r.clear_screen))
    else $error("scroll and clear raised together");

  a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.clear_screen |->
      !out_r.cell_write &&
      out_r.cursor_index == IDX_W'(FIRST_TEXT_ROW * SCREEN_COLUMNS))
    else $error("clear did not home the cursor");

  a_idle_address: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.cell_write |-> out_r.cell_address == '0)
    else $error("address set without a cell write");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.cursor_index < IDX_W'(SCREEN_ROWS * SCREEN_COLUMNS))
    else $error("cursor index off screen");

endmodule
`default_nettype wire

// ===== hdl/tcc_cursor.sv =====
`default_nettype none
module tcc_cursor import tcc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic              mode,
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic [ATTR_W-1:0] attr,
  output tcc_result_t            res
);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W:0]   col_w;
  logic [ROW_W:0]   row_w;

  always_comb begin
    col_w            = {1'b0, col_r};
    row_w            = {1'b0, row_r};
    res.cell_write   = 1'b0;
    res.cell_address = '0;
    res.cell_word    = {attr, CHAR_SPACE};
    res.scroll_up    = 1'b0;
    res.clear_screen = 1'b0;
    if (mode) begin
      res.clear_screen = 1'b1;
      col_w = '0;
      row_w = (ROW_W+1)'(FIRST_TEXT_ROW);
    end else begin
      priority if (char_code >= CHAR_SPACE) begin
        res.cell_write   = 1'b1;
        res.cell_address = cell_index(row_r, col_r);
        res.cell_word    = {attr, char_code};
        col_w = col_w + 1'b1;
      end else if (char_code == CHAR_BS) begin
        if (col_r != '0) col_w = col_w - 1'b1;
      end else if (char_code == CHAR_TAB) begin
        col_w = TAB_STOPS[col_r];
      end else if (char_code == CHAR_CR) begin
        col_w = '0;
      end else if (char_code == CHAR_LF) begin
        col_w = '0;
        row_w = row_w + 1'b1;
      end else begin
        // ignore other control bytes
      end
      // wrap past the last column
      if (col_w >= (COL_W+1)'(SCREEN_COLUMNS)) begin
        col_w = '0;
        row_w = row_w + 1'b1;
      end
      // hold the bottom row and ask for a scroll
      if (row_w >= (ROW_W+1)'(SCREEN_ROWS)) begin
        res.scroll_up = 1'b1;
        row_w = (ROW_W+1)'(SCREEN_ROWS - 1);
      end
    end
    col_nxt          = col_w[COL_W-1:0];
    row_nxt          = row_w[ROW_W-1:0];
    res.cursor_index = cell_index(row_nxt, col_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= ROW_W'(FIRST_TEXT_ROW);
    end else if (step) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
module tb_top import tcc_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_PUT   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  localparam int PHASE_ITEMS  = 275;
  localparam int PHASE_COUNT  = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_CYCLES  = 4;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tcc_in_if  in_ch ();
  tcc_out_if out_ch ();

  text_console_cursor_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_ch),
    .out_item  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // console state as the block should hold it
  logic [COL_W-1:0]   cur_col;
  logic [ROW_W-1:0]   cur_row;
  logic [COLOR_W-1:0] text_colour;
  logic [COLOR_W-1:0] back_colour;

  tcc_result_t console_updates_q [$];

  int error_count = 0;
  int burst_left  = 16;
  int stall_left  = 0;
  int stall_mode  = 0;
  int stall_tick  = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Work out the update that one byte causes and advance the cursor.
  function automatic tcc_result_t console_step(input logic mode,
                                               input logic [CHAR_W-1:0] code);
    tcc_result_t       r;
    int                col;
    int                row;
    logic [ATTR_W-1:0] attr;
    attr = {back_colour, text_colour};
    col  = cur_col;
    row  = cur_row;
    r    = '0;
    r.cell_word = {attr, CHAR_SPACE};
    if (mode == MODE_CLEAR) begin
      r.clear_screen = 1'b1;
      col = 0;
      row = FIRST_TEXT_ROW;
    end else begin
      if (code >= CHAR_SPACE) begin
        r.cell_write   = 1'b1;
        r.cell_address = IDX_W'(row * SCREEN_COLUMNS + col);
        r.cell_word    = {attr, code};
        col++;
      end else if (code == CHAR_BS) begin
        if (col != 0) col--;
      end else if (code == CHAR_TAB) begin
        col = col + TAB_WIDTH - (col % TAB_WIDTH);
      end else if (code == CHAR_CR) begin
        col = 0;
      end else if (code == CHAR_LF) begin
        col = 0;
        row++;
      end
      if (col >= SCREEN_COLUMNS) begin
        col = 0;
        row++;
      end
      if (row >= SCREEN_ROWS) begin
        r.scroll_up = 1'b1;
        row = SCREEN_ROWS - 1;
      end
    end
    cur_col = COL_W'(col);
    cur_row = ROW_W'(row);
    r.cursor_index = IDX_W'(cur_row * SCREEN_COLUMNS + cur_col);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                             input logic [WORD_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  task automatic check_update();
    tcc_result_t want;
    if (console_updates_q.size() == 0) begin
      report_mismatch($sformatf("unexpected item, cursor_index %0d", out_ch.cursor_index));
    end else begin
      want = console_updates_q.pop_front();
      check_field("cell_write",   WORD_W'(out_ch.cell_write),   WORD_W'(want.cell_write));
      check_field("cell_address", WORD_W'(out_ch.cell_address), WORD_W'(want.cell_address));
      check_field("cell_word",    out_ch.cell_word,             want.cell_word);
      check_field("scroll_up",    WORD_W'(out_ch.scroll_up),    WORD_W'(want.scroll_up));
      check_field("clear_screen", WORD_W'(out_ch.clear_screen), WORD_W'(want.clear_screen));
      check_field("cursor_index", WORD_W'(out_ch.cursor_index), WORD_W'(want.cursor_index));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_update();
  end

  // receiver: switch between always ready, random and periodic stalls
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(32, 256);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 4) == 0);
        default: out_ch.ready <= (stall_tick % 7) > 2;
      endcase
    end
  end

  // Offer one item and hold it until taken; gap after each burst.
  task automatic send_item(input logic mode, input logic [CHAR_W-1:0] code);
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.char_code <= code;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    console_updates_q.push_back(console_step(mode, code));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (console_updates_q.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_colour(input cfg_reg_t idx, input logic [COLOR_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TEXT_COLOR) text_colour = value;
    else                       back_colour = value;
  endtask

  // reset colours, each handled control code and some ignored ones, printable extremes, clear mode
  task automatic test_control_codes();
    send_item(MODE_PUT, 8'h41);
    send_item(MODE_PUT, 8'hFF);
    send_item(MODE_PUT, CHAR_SPACE);
    send_item(MODE_PUT, CHAR_BS);
    send_item(MODE_PUT, CHAR_CR);
    send_item(MODE_PUT, CHAR_BS);
    send_item(MODE_PUT, CHAR_TAB);
    send_item(MODE_PUT, CHAR_TAB);
    send_item(MODE_PUT, 8'h7E);
    send_item(MODE_PUT, CHAR_TAB);
    send_item(MODE_PUT, 8'h00);
    send_item(MODE_PUT, 8'h1F);
    send_item(MODE_PUT, 8'h1B);
    send_item(MODE_PUT, CHAR_LF);
    send_item(MODE_PUT, 8'h80);
    send_item(MODE_CLEAR, 8'hFF);
    send_item(MODE_PUT, CHAR_BS);
    send_item(MODE_CLEAR, 8'h00);
  endtask

  // column wrap, write with scroll in one step, scroll by LF and by TAB
  task automatic test_wrap_and_scroll();
    send_item(MODE_CLEAR, 8'h55);
    repeat (9) send_item(MODE_PUT, CHAR_TAB);
    repeat (8) send_item(MODE_PUT, CHAR_W'($urandom_range(8'h20, 8'hFF)));
    repeat (22) send_item(MODE_PUT, CHAR_LF);
    repeat (9) send_item(MODE_PUT, CHAR_TAB);
    repeat (8) send_item(MODE_PUT, CHAR_W'($urandom_range(8'h20, 8'hFF)));
    send_item(MODE_PUT, CHAR_LF);
    repeat (10) send_item(MODE_PUT, CHAR_TAB);
    send_item(MODE_PUT, CHAR_CR);
    send_item(MODE_CLEAR, 8'hAA);
  endtask

  task automatic send_random_item();
    int pick;
    pick = $urandom_range(0, 199);
    if (pick == 0)       send_item(MODE_CLEAR, CHAR_W'($urandom_range(0, 255)));
    else if (pick <= 30) send_item(MODE_PUT, CHAR_LF);
    else if (pick <= 48) send_item(MODE_PUT, CHAR_TAB);
    else if (pick <= 62) send_item(MODE_PUT, CHAR_BS);
    else if (pick <= 72) send_item(MODE_PUT, CHAR_CR);
    else if (pick <= 88) send_item(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)));
    else if (pick <= 96) send_item(MODE_PUT, CHAR_W'($urandom_range(0, 8'h1F)));
    else                 send_item(MODE_PUT, CHAR_W'($urandom_range(8'h20, 8'hFF)));
  endtask

  // random text under several colour settings, extremes first
  task automatic test_random_text();
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin fg = 4'hF; bg = 4'hF; end
        1: begin fg = 4'h0; bg = 4'h0; end
        2: begin fg = 4'hF; bg = 4'h0; end
        3: begin fg = 4'h0; bg = 4'hF; end
        default: begin
          fg = COLOR_W'($urandom_range(0, 15));
          bg = COLOR_W'($urandom_range(0, 15));
        end
      endcase
      write_colour(REG_TEXT_COLOR, fg);
      write_colour(REG_BACK_COLOR, bg);
      repeat (PHASE_ITEMS) send_random_item();
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_TEXT_COLOR;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= MODE_PUT;
    in_ch.char_code <= '0;
    cur_col     = '0;
    cur_row     = ROW_W'(FIRST_TEXT_ROW);
    text_colour = TEXT_COLOR_RESET;
    back_colour = BACK_COLOR_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_control_codes();
    test_wrap_and_scroll();
    test_random_text();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && console_updates_q.size() == 0) begin
      $display("PASS text_console_cursor_engine");
    end else begin
      $display("FAIL text_console_cursor_engine");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL text_console_cursor_engine");
    $finish;
  end

endmodule
